// ----- rtl/aet_pkg.sv -----
`timescale 1ns / 1ps
package aet_pkg;

    localparam int DEF_MAX_POINTS   = 1024;
    localparam int DEF_CORDIC_STEPS = 16;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int XY_W    = 36;
    localparam int Z_W     = 20;
    localparam int ANG_W   = 21;
    localparam int ACC_W   = 23;
    localparam int IDX_W   = 10;
    localparam int CFG_W   = 1;

    localparam logic [CFG_W-1:0] CFG_OBSERVER_X = 1'b0;
    localparam logic [CFG_W-1:0] CFG_OBSERVER_Y = 1'b1;

    localparam logic signed [ACC_W-1:0] PI_Q      = 23'sd205887;
    localparam logic signed [ACC_W-1:0] TWO_PI_Q  = 23'sd411775;
    localparam logic signed [ACC_W-1:0] FOUR_PI_Q = 23'sd823550;
    localparam logic signed [ACC_W-1:0] JUMP_Q    = 23'sd196608;

    typedef struct packed {
        logic signed [XY_W-1:0]    x;
        logic signed [XY_W-1:0]    y;
        logic signed [Z_W-1:0]     z;
        logic        [COORD_W-1:0] px;
        logic        [COORD_W-1:0] py;
        logic                      last;
        logic                      zero;
    } t_cord;

    function automatic logic signed [Z_W-1:0] atan_q(input int step);
        logic signed [Z_W-1:0] a;
        case (step)
            0:       a = 20'sd51472;
            1:       a = 20'sd30386;
            2:       a = 20'sd16055;
            3:       a = 20'sd8150;
            4:       a = 20'sd4091;
            5:       a = 20'sd2047;
            6:       a = 20'sd1024;
            7:       a = 20'sd512;
            8:       a = 20'sd256;
            9:       a = 20'sd128;
            10:      a = 20'sd64;
            11:      a = 20'sd32;
            12:      a = 20'sd16;
            13:      a = 20'sd8;
            14:      a = 20'sd4;
            15:      a = 20'sd2;
            16:      a = 20'sd1;
            default: a = 20'sd0;
        endcase
        return a;
    endfunction

    function automatic logic signed [ACC_W-1:0] clamp_lim(
        input logic signed [ACC_W-1:0] v,
        input logic signed [ACC_W-1:0] lim
    );
        logic signed [ACC_W-1:0] r;
        if (v > lim) begin
            r = lim;
        end else if (v < -lim) begin
            r = -lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- rtl/aet_prep.sv -----
`timescale 1ns / 1ps
module aet_prep
    import aet_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [COORD_W-1:0] i_point_x,
    input  logic [COORD_W-1:0] i_point_y,
    input  logic               i_last_point,
    input  logic [COORD_W-1:0] i_obs_x,
    input  logic [COORD_W-1:0] i_obs_y,
    output logic               o_valid,
    output t_cord              o_d
);

    logic                      r_v1;
    logic signed [DIFF_W-1:0]  r_dx;
    logic signed [DIFF_W-1:0]  r_dy;
    logic        [COORD_W-1:0] r_px;
    logic        [COORD_W-1:0] r_py;
    logic                      r_last;
    logic signed [DIFF_W-1:0]  n_dx;
    logic signed [DIFF_W-1:0]  n_dy;
    logic signed [XY_W-1:0]    w_xe;
    logic signed [XY_W-1:0]    w_ye;
    logic                      r_v2;
    t_cord                     r_d;
    t_cord                     n_d;

    assign n_dx = $signed({i_point_x[COORD_W-1], i_point_x}) - $signed({i_obs_x[COORD_W-1], i_obs_x});
    assign n_dy = $signed({i_point_y[COORD_W-1], i_point_y}) - $signed({i_obs_y[COORD_W-1], i_obs_y});

    assign w_xe = XY_W'(r_dx);
    assign w_ye = XY_W'(r_dy);

    always_comb begin
        n_d      = '0;
        n_d.px   = r_px;
        n_d.py   = r_py;
        n_d.last = r_last;
        n_d.zero = (r_dx == '0) && (r_dy == '0);
        if (r_dx < 0) begin
            n_d.x = -w_xe;
            n_d.y = -w_ye;
            n_d.z = (r_dy >= 0) ? Z_W'(PI_Q) : Z_W'(-PI_Q);
        end else begin
            n_d.x = w_xe;
            n_d.y = w_ye;
            n_d.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_px   <= i_point_x;
            r_py   <= i_point_y;
            r_last <= i_last_point;
            r_d    <= n_d;
        end
    end

    assign o_valid = r_v2;
    assign o_d     = r_d;

endmodule

// ----- rtl/aet_cell.sv -----
`timescale 1ns / 1ps
module aet_cell
    import aet_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_cord i_d,
    output logic  o_valid,
    output t_cord o_d
);

    localparam logic signed [Z_W-1:0] ATAN_STEP = atan_q(STEP);

    logic signed [XY_W-1:0] w_xs;
    logic signed [XY_W-1:0] w_ys;
    logic                   r_valid;
    t_cord                  r_d;
    t_cord                  n_d;

    assign w_xs = i_d.x >>> STEP;
    assign w_ys = i_d.y >>> STEP;

    always_comb begin
        n_d = i_d;
        if (i_d.y >= 0) begin
            n_d.x = i_d.x + w_ys;
            n_d.y = i_d.y - w_xs;
            n_d.z = i_d.z + ATAN_STEP;
        end else begin
            n_d.x = i_d.x - w_ys;
            n_d.y = i_d.y + w_xs;
            n_d.z = i_d.z - ATAN_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

// ----- rtl/aet_track.sv -----
`timescale 1ns / 1ps
module aet_track
    import aet_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_cord              i_d,
    output logic               o_out_valid,
    output logic [COORD_W-1:0] o_min_x,
    output logic [COORD_W-1:0] o_min_y,
    output logic [IDX_W-1:0]   o_min_index,
    output logic [COORD_W-1:0] o_max_x,
    output logic [COORD_W-1:0] o_max_y,
    output logic [IDX_W-1:0]   o_max_index
);

    localparam int                CNT_W   = $clog2(MAX_POINTS);
    localparam logic [CNT_W-1:0]  CNT_TOP = CNT_W'(MAX_POINTS - 1);

    logic                      r_first;
    logic [CNT_W-1:0]          r_count;
    logic signed [ANG_W-1:0]   r_prev;
    logic signed [ANG_W-1:0]   r_wrap;
    logic signed [ANG_W-1:0]   r_least;
    logic signed [ANG_W-1:0]   r_great;
    logic [COORD_W-1:0]        r_lx;
    logic [COORD_W-1:0]        r_ly;
    logic [COORD_W-1:0]        r_gx;
    logic [COORD_W-1:0]        r_gy;
    logic [CNT_W-1:0]          r_lpos;
    logic [CNT_W-1:0]          r_gpos;

    logic [CNT_W-1:0]          n_count;
    logic signed [ANG_W-1:0]   n_prev;
    logic signed [ANG_W-1:0]   n_wrap;
    logic signed [ANG_W-1:0]   n_least;
    logic signed [ANG_W-1:0]   n_great;
    logic [COORD_W-1:0]        n_lx;
    logic [COORD_W-1:0]        n_ly;
    logic [COORD_W-1:0]        n_gx;
    logic [COORD_W-1:0]        n_gy;
    logic [CNT_W-1:0]          n_lpos;
    logic [CNT_W-1:0]          n_gpos;

    logic signed [ACC_W-1:0]   w_raw;
    logic signed [ACC_W-1:0]   w_ang0;
    logic signed [ACC_W-1:0]   w_del;
    logic signed [ACC_W-1:0]   w_ang;
    logic signed [ACC_W-1:0]   w_wrap;

    logic                      r_out_valid;
    logic [COORD_W-1:0]        r_min_x;
    logic [COORD_W-1:0]        r_min_y;
    logic [CNT_W+IDX_W-1:0]    r_min_idx;
    logic [COORD_W-1:0]        r_max_x;
    logic [COORD_W-1:0]        r_max_y;
    logic [CNT_W+IDX_W-1:0]    r_max_idx;

    always_comb begin
        w_raw  = i_d.zero ? '0 : clamp_lim(ACC_W'(i_d.z), PI_Q);
        w_ang0 = clamp_lim(w_raw + ACC_W'(r_wrap), FOUR_PI_Q);
        w_del  = w_ang0 - ACC_W'(r_prev);
        w_wrap = ACC_W'(r_wrap);
        w_ang  = w_ang0;
        if (w_del > JUMP_Q) begin
            w_wrap = clamp_lim(ACC_W'(r_wrap) - TWO_PI_Q, FOUR_PI_Q);
            w_ang  = clamp_lim(w_ang0 - TWO_PI_Q, FOUR_PI_Q);
        end else if (w_del < -JUMP_Q) begin
            w_wrap = clamp_lim(ACC_W'(r_wrap) + TWO_PI_Q, FOUR_PI_Q);
            w_ang  = clamp_lim(w_ang0 + TWO_PI_Q, FOUR_PI_Q);
        end

        n_prev  = r_prev;
        n_wrap  = r_wrap;
        n_least = r_least;
        n_great = r_great;
        n_lx    = r_lx;
        n_ly    = r_ly;
        n_gx    = r_gx;
        n_gy    = r_gy;
        n_lpos  = r_lpos;
        n_gpos  = r_gpos;
        if (!r_first) begin
            n_wrap  = '0;
            n_prev  = ANG_W'(w_raw);
            n_least = ANG_W'(w_raw);
            n_great = ANG_W'(w_raw);
            n_lx    = i_d.px;
            n_ly    = i_d.py;
            n_gx    = i_d.px;
            n_gy    = i_d.py;
            n_lpos  = r_count;
            n_gpos  = r_count;
        end else begin
            n_wrap = ANG_W'(w_wrap);
            n_prev = ANG_W'(w_ang);
            if (w_ang > ACC_W'(r_great)) begin
                n_great = ANG_W'(w_ang);
                n_gx    = i_d.px;
                n_gy    = i_d.py;
                n_gpos  = r_count;
            end
            if (w_ang < ACC_W'(r_least)) begin
                n_least = ANG_W'(w_ang);
                n_lx    = i_d.px;
                n_ly    = i_d.py;
                n_lpos  = r_count;
            end
        end
        n_count = (r_count != CNT_TOP) ? r_count + 1'b1 : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= 1'b0;
            r_count     <= '0;
            r_wrap      <= '0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= i_valid && i_d.last;
            if (i_valid) begin
                if (i_d.last) begin
                    r_first <= 1'b0;
                    r_count <= '0;
                    r_wrap  <= '0;
                end else begin
                    r_first <= 1'b1;
                    r_count <= n_count;
                    r_wrap  <= n_wrap;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_prev  <= n_prev;
            r_least <= n_least;
            r_great <= n_great;
            r_lx    <= n_lx;
            r_ly    <= n_ly;
            r_gx    <= n_gx;
            r_gy    <= n_gy;
            r_lpos  <= n_lpos;
            r_gpos  <= n_gpos;
            if (i_d.last) begin
                r_min_x   <= n_lx;
                r_min_y   <= n_ly;
                r_min_idx <= {{IDX_W{1'b0}}, n_lpos};
                r_max_x   <= n_gx;
                r_max_y   <= n_gy;
                r_max_idx <= {{IDX_W{1'b0}}, n_gpos};
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_min_x     = r_min_x;
    assign o_min_y     = r_min_y;
    assign o_min_index = r_min_idx[IDX_W-1:0];
    assign o_max_x     = r_max_x;
    assign o_max_y     = r_max_y;
    assign o_max_index = r_max_idx[IDX_W-1:0];

endmodule

// ----- rtl/angular_extent_tracker_unit.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake                 payload
// in        sink       i_in_valid / o_in_ready   i_point_x, i_point_y, i_last_point
// out       source     o_out_valid / i_out_ready o_min_x, o_min_y, o_min_index,
//                                                o_max_x, o_max_y, o_max_index
// cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one point accepted per cycle while o_in_ready is high; a point passes two prep
// stages, CORDIC_STEPS cordic cells and one tracking stage
// the whole chain holds while a result waits on i_out_ready, and o_in_ready drops
// synchronous active-low reset clears valid bits, path state and observer registers
module angular_extent_tracker_unit
    import aet_pkg::*;
#(
    parameter int MAX_POINTS   = DEF_MAX_POINTS,
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [COORD_W-1:0] i_point_x,
    input  logic [COORD_W-1:0] i_point_y,
    input  logic               i_last_point,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [COORD_W-1:0] o_min_x,
    output logic [COORD_W-1:0] o_min_y,
    output logic [IDX_W-1:0]   o_min_index,
    output logic [COORD_W-1:0] o_max_x,
    output logic [COORD_W-1:0] o_max_y,
    output logic [IDX_W-1:0]   o_max_index,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_index,
    input  logic [COORD_W-1:0] i_cfg_data
);

    logic               w_en;
    logic [COORD_W-1:0] r_obs_x;
    logic [COORD_W-1:0] r_obs_y;
    logic               w_valid [0:CORDIC_STEPS];
    t_cord              w_d     [0:CORDIC_STEPS];

    assign w_en        = !o_out_valid || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obs_x <= '0;
            r_obs_y <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OBSERVER_X: r_obs_x <= i_cfg_data;
                CFG_OBSERVER_Y: r_obs_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    aet_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (i_in_valid),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_last_point (i_last_point),
        .i_obs_x      (r_obs_x),
        .i_obs_y      (r_obs_y),
        .o_valid      (w_valid[0]),
        .o_d          (w_d[0])
    );

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        aet_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_d     (w_d[g]),
            .o_valid (w_valid[g+1]),
            .o_d     (w_d[g+1])
        );
    end

    aet_track #(
        .MAX_POINTS (MAX_POINTS)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (w_valid[CORDIC_STEPS]),
        .i_d         (w_d[CORDIC_STEPS]),
        .o_out_valid (o_out_valid),
        .o_min_x     (o_min_x),
        .o_min_y     (o_min_y),
        .o_min_index (o_min_index),
        .o_max_x     (o_max_x),
        .o_max_y     (o_max_y),
        .o_max_index (o_max_index)
    );

endmodule

// ----- rtl/aet_checker.sv -----
`timescale 1ns / 1ps
module aet_checker
    import aet_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [COORD_W-1:0] o_min_x,
    input logic [IDX_W-1:0]   o_min_index,
    input logic [COORD_W-1:0] o_max_x,
    input logic [IDX_W-1:0]   o_max_index
);

    // a waiting result stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a waiting result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_min_x) && $stable(o_min_index)
            && $stable(o_max_x) && $stable(o_max_index))
        else $error("result payload changed while stalled");

    // the chain freezes while a result waits
    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("request taken while output stalled");

    // free output slot means the chain moves
    a_free_takes_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with no result waiting");

    // reset empties the output
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind angular_extent_tracker_unit aet_checker u_aet_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_min_x     (o_min_x),
    .o_min_index (o_min_index),
    .o_max_x     (o_max_x),
    .o_max_index (o_max_index)
);

// ----- verif/aet_extent_checker.sv -----
`timescale 1ns / 1ps
module aet_extent_checker
    import aet_pkg::*;
#(
    parameter int MAX_POINTS   = DEF_MAX_POINTS,
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [COORD_W-1:0] i_point_x,
    input  logic [COORD_W-1:0] i_point_y,
    input  logic               i_last_point,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [COORD_W-1:0] i_min_x,
    input  logic [COORD_W-1:0] i_min_y,
    input  logic [IDX_W-1:0]   i_min_index,
    input  logic [COORD_W-1:0] i_max_x,
    input  logic [COORD_W-1:0] i_max_y,
    input  logic [IDX_W-1:0]   i_max_index,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_index,
    input  logic [COORD_W-1:0] i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam longint Q_PI      = 205887;
    localparam longint Q_TWO_PI  = 411775;
    localparam longint Q_FOUR_PI = 823550;
    localparam longint Q_JUMP    = 196608;
    localparam int     LUT_SIZE  = 24;
    localparam int     MAX_LINES = 60;

    typedef struct packed {
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] min_y;
        logic [IDX_W-1:0]   min_index;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] max_y;
        logic [IDX_W-1:0]   max_index;
    } t_extent;

    t_extent extent_q[$];
    t_extent want;
    int fail_count = 0;

    logic [COORD_W-1:0] obs_x;
    logic [COORD_W-1:0] obs_y;
    logic               seen;
    int                 next_pos;
    longint             prev_ang;
    longint             wrap_acc;
    longint             lo_ang;
    longint             hi_ang;
    logic [COORD_W-1:0] lo_x;
    logic [COORD_W-1:0] lo_y;
    logic [COORD_W-1:0] hi_x;
    logic [COORD_W-1:0] hi_y;
    int                 lo_pos;
    int                 hi_pos;
    longint             atan_lut [0:LUT_SIZE-1];

    // round(atan(2^-k) * 2^16)
    initial begin : build_atan
        real t;
        int k;
        t = 1.0;
        for (k = 0; k < LUT_SIZE; k++) begin
            atan_lut[k] = longint'($rtoi($atan(t) * 65536.0 + 0.5));
            t = t / 2.0;
        end
    end

    function automatic longint limit(input longint v, input longint lim);
        longint r;
        if (v > lim) begin
            r = lim;
        end else if (v < -lim) begin
            r = -lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

    task automatic clear_path();
        seen     = 1'b0;
        next_pos = 0;
        prev_ang = 0;
        wrap_acc = 0;
        lo_ang   = 0;
        hi_ang   = 0;
        lo_x     = '0;
        lo_y     = '0;
        hi_x     = '0;
        hi_y     = '0;
        lo_pos   = 0;
        hi_pos   = 0;
    endtask

    task automatic report_mismatch(input string what, input logic [COORD_W-1:0] got,
                                   input logic [COORD_W-1:0] exp_val);
        if (fail_count < MAX_LINES) begin
            $display("%0t ns extent mismatch %s: got %h want %h", $time, what, got, exp_val);
        end
        fail_count++;
    endtask

    // bearing of one point, unwrap, then update the running extremes
    task automatic track_extents(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                                 input logic last);
        longint  dx;
        longint  dy;
        longint  xv;
        longint  yv;
        longint  xs;
        longint  ys;
        longint  raw;
        longint  ang;
        longint  step_ang;
        int      i;
        t_extent res;
        dx  = longint'($signed(px)) - longint'($signed(obs_x));
        dy  = longint'($signed(py)) - longint'($signed(obs_y));
        raw = 0;
        if (dx != 0 || dy != 0) begin
            xv = dx;
            yv = dy;
            if (xv < 0) begin
                raw = (yv >= 0) ? Q_PI : -Q_PI;
                xv  = -xv;
                yv  = -yv;
            end
            for (i = 0; i < CORDIC_STEPS; i++) begin
                step_ang = (i < LUT_SIZE) ? atan_lut[i] : 0;
                xs = xv >>> i;
                ys = yv >>> i;
                if (yv >= 0) begin
                    xv  = xv + ys;
                    yv  = yv - xs;
                    raw = raw + step_ang;
                end else begin
                    xv  = xv - ys;
                    yv  = yv + xs;
                    raw = raw - step_ang;
                end
            end
            raw = limit(raw, Q_PI);
        end
        if (!seen) begin
            seen     = 1'b1;
            wrap_acc = 0;
            prev_ang = raw;
            lo_ang   = raw;
            hi_ang   = raw;
            lo_x     = px;
            lo_y     = py;
            hi_x     = px;
            hi_y     = py;
            lo_pos   = next_pos;
            hi_pos   = next_pos;
        end else begin
            ang = limit(raw + wrap_acc, Q_FOUR_PI);
            if (ang - prev_ang > Q_JUMP) begin
                wrap_acc = limit(wrap_acc - Q_TWO_PI, Q_FOUR_PI);
                ang      = limit(ang - Q_TWO_PI, Q_FOUR_PI);
            end else if (ang - prev_ang < -Q_JUMP) begin
                wrap_acc = limit(wrap_acc + Q_TWO_PI, Q_FOUR_PI);
                ang      = limit(ang + Q_TWO_PI, Q_FOUR_PI);
            end
            if (ang > hi_ang) begin
                hi_ang = ang;
                hi_x   = px;
                hi_y   = py;
                hi_pos = next_pos;
            end
            if (ang < lo_ang) begin
                lo_ang = ang;
                lo_x   = px;
                lo_y   = py;
                lo_pos = next_pos;
            end
            prev_ang = ang;
        end
        if (next_pos < MAX_POINTS - 1) begin
            next_pos++;
        end
        if (last) begin
            res.min_x     = lo_x;
            res.min_y     = lo_y;
            res.min_index = lo_pos[IDX_W-1:0];
            res.max_x     = hi_x;
            res.max_y     = hi_y;
            res.max_index = hi_pos[IDX_W-1:0];
            extent_q      = {extent_q, res};
            clear_path();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            obs_x = '0;
            obs_y = '0;
            clear_path();
            extent_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (extent_q.size() == 0) begin
                    report_mismatch("result with no request pending", i_min_x, '0);
                end else begin
                    want = extent_q.pop_front();
                    if (i_min_x !== want.min_x) begin
                        report_mismatch("min_x", i_min_x, want.min_x);
                    end
                    if (i_min_y !== want.min_y) begin
                        report_mismatch("min_y", i_min_y, want.min_y);
                    end
                    if (i_min_index !== want.min_index) begin
                        report_mismatch("min_index", COORD_W'(i_min_index),
                                        COORD_W'(want.min_index));
                    end
                    if (i_max_x !== want.max_x) begin
                        report_mismatch("max_x", i_max_x, want.max_x);
                    end
                    if (i_max_y !== want.max_y) begin
                        report_mismatch("max_y", i_max_y, want.max_y);
                    end
                    if (i_max_index !== want.max_index) begin
                        report_mismatch("max_index", COORD_W'(i_max_index),
                                        COORD_W'(want.max_index));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_OBSERVER_X: obs_x = i_cfg_data;
                    CFG_OBSERVER_Y: obs_y = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                track_extents(i_point_x, i_point_y, i_last_point);
            end
        end
        o_pending    <= extent_q.size();
        o_fail_count <= fail_count;
    end

endmodule

// ----- verif/angular_extent_tracker_unit_tb.sv -----
`timescale 1ns / 1ps
module angular_extent_tracker_unit_tb;
    import aet_pkg::*;

    localparam int MAX_POINTS    = DEF_MAX_POINTS;
    localparam int CORDIC_STEPS  = DEF_CORDIC_STEPS;
    localparam int LATENCY       = CORDIC_STEPS + 3;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_POINTS = 800;
    localparam int PHASE_POINTS  = 90;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [COORD_W-1:0] point_x = '0;
    logic [COORD_W-1:0] point_y = '0;
    logic               last_point = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] min_y;
    logic [IDX_W-1:0]   min_index;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] max_y;
    logic [IDX_W-1:0]   max_index;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_index = '0;
    logic [COORD_W-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int stall_left = 0;
    logic calm_out = 1'b0;
    logic calm_in = 1'b0;
    int items_sent = 0;
    logic [COORD_W-1:0] cur_obs_x = '0;
    logic [COORD_W-1:0] cur_obs_y = '0;

    always #1 clk = ~clk;

    angular_extent_tracker_unit #(
        .MAX_POINTS  (MAX_POINTS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_point_x   (point_x),
        .i_point_y   (point_y),
        .i_last_point(last_point),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_min_x     (min_x),
        .o_min_y     (min_y),
        .o_min_index (min_index),
        .o_max_x     (max_x),
        .o_max_y     (max_y),
        .o_max_index (max_index),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    aet_extent_checker #(
        .MAX_POINTS  (MAX_POINTS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) extent_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_point_x   (point_x),
        .i_point_y   (point_y),
        .i_last_point(last_point),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_min_x     (min_x),
        .i_min_y     (min_y),
        .i_min_index (min_index),
        .i_max_x     (max_x),
        .i_max_y     (max_y),
        .i_max_index (max_index),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // result side back-pressure, with calm stretches
    always @(posedge clk) begin : out_side
        int wait_cycles;
        if (!rst_n) begin
            out_ready  <= 1'b1;
            stall_left <= 0;
        end else if (out_valid && out_ready) begin
            if ($urandom_range(0, 7) == 0) begin
                calm_out <= !calm_out;
            end
            wait_cycles = calm_out ? 0 : $urandom_range(0, 12);
            stall_left <= wait_cycles;
            out_ready  <= (wait_cycles == 0);
        end else if (out_valid && !out_ready) begin
            if (stall_left <= 1) begin
                out_ready <= 1'b1;
            end else begin
                stall_left <= stall_left - 1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic last);
        int gap;
        gap = calm_in ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        point_x    <= x;
        point_y    <= y;
        last_point <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [COORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic new_phase(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        drain();
        cur_obs_x = x;
        cur_obs_y = y;
        write_reg(CFG_OBSERVER_X, x);
        write_reg(CFG_OBSERVER_Y, y);
        cfg_valid <= 1'b0;
    endtask

    // points on a circle around the observer, turning by step each point
    task automatic send_orbit(input int len, input real radius, input real start,
                              input real step);
        real    ang;
        longint px;
        longint py;
        int     k;
        ang = start;
        for (k = 0; k < len; k++) begin
            px = longint'($signed(cur_obs_x)) + longint'($rtoi(radius * $cos(ang)));
            py = longint'($signed(cur_obs_y)) + longint'($rtoi(radius * $sin(ang)));
            send_point(px[COORD_W-1:0], py[COORD_W-1:0], k == len - 1);
            ang = ang + step;
        end
    endtask

    function automatic logic [COORD_W-1:0] corner_value(input int pick);
        logic [COORD_W-1:0] v;
        case (pick)
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0000;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

    initial begin : stimulus
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        int   phase_start;
        int   len;
        int   kind;
        int   k;
        real  radius;
        real  step;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // observer at origin: lone point on the observer, then the four quadrants,
        // both signs of pi and a wrap in each direction
        new_phase(32'h0, 32'h0);
        send_point(32'h0, 32'h0, 1'b1);
        send_point(32'h7FFF_FFFF, 32'h0, 1'b0);
        send_point(32'h0, 32'h7FFF_FFFF, 1'b0);
        send_point(32'hFFFF_0000, 32'h0000_0001, 1'b0);
        send_point(32'hFFFF_0000, 32'hFFFF_FFFF, 1'b0);
        send_point(32'h0, 32'h8000_0000, 1'b0);
        send_point(32'h0, 32'h0, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h8000_0000, 32'h0, 1'b1);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_orbit(8, 1048576.0, 0.0, 1.1);

        // observer in the corners: widest differences both ways
        new_phase(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_point(32'h0, 32'h0, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 1'b1);
        new_phase(32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);

        while (items_sent < 25 + RANDOM_POINTS) begin
            case ($urandom_range(0, 3))
                0: begin
                    ox = $urandom;
                    oy = $urandom;
                end
                1: begin
                    ox = 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
                    oy = 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
                end
                2: begin
                    ox = corner_value($urandom_range(0, 2));
                    oy = corner_value($urandom_range(0, 2));
                end
                default: begin
                    ox = '0;
                    oy = '0;
                end
            endcase
            new_phase(ox, oy);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_POINTS) begin
                calm_in = ($urandom_range(0, 3) == 0);
                kind = $urandom_range(0, 9);
                if (kind < 6) begin
                    len    = $urandom_range(1, 40);
                    radius = (1.0 + $urandom_range(0, 999) / 1000.0) *
                             real'(longint'(1) << $urandom_range(4, 28));
                    if (kind == 5) begin
                        step = 2.6 + $urandom_range(0, 1000) / 1000.0;
                    end else begin
                        step = 0.05 + $urandom_range(0, 1250) / 1000.0;
                    end
                    if ($urandom_range(0, 1) == 0) begin
                        step = -step;
                    end
                    send_orbit(len, radius, $urandom_range(0, 62831) / 10000.0, step);
                end else if (kind < 8) begin
                    len = $urandom_range(1, 12);
                    for (k = 0; k < len; k++) begin
                        send_point($urandom, $urandom, k == len - 1);
                    end
                end else begin
                    // on or right next to the observer
                    len = $urandom_range(1, 10);
                    for (k = 0; k < len; k++) begin
                        send_point(cur_obs_x + 32'($urandom_range(0, 2)) - 32'd1,
                                   cur_obs_y + 32'($urandom_range(0, 2)) - 32'd1,
                                   k == len - 1);
                    end
                end
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
